// ===== design/fpalu_pkg.sv =====
// ----------------------------------------------------------------------------
// fpalu_pkg - shared types and constants for the Q24.8 fixed-point ALU
// Command codes, operation classes and the structs passed between the
// front end, the execute pipeline and the result queue.
// ----------------------------------------------------------------------------
package fpalu_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRONT_DEPTH = 4;   // power of two
  localparam int unsigned RESULT_DEPTH = 2;  // power of two
  localparam int unsigned DIV_BPS     = 4;   // quotient bits per divider stage

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_FROM_INT = 4'd6,
    CMD_TO_INT   = 4'd7,
    CMD_LT       = 4'd8,
    CMD_LE       = 4'd9,
    CMD_GT       = 4'd10,
    CMD_GE       = 4'd11,
    CMD_EQ       = 4'd12,
    CMD_NE       = 4'd13,
    CMD_MIN      = 4'd14,
    CMD_MAX      = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_CMP    = 2'd1,
    CLS_MUL    = 2'd2,
    CLS_DIV    = 2'd3
  } op_class_e;

  typedef struct packed {
    cmd_e      cmd;
    op_class_e cls;
  } op_ctrl_t;

  typedef struct packed {
    op_ctrl_t                  ctrl;
    logic signed [DATA_W-1:0]  a;
    logic signed [DATA_W-1:0]  b;
  } front_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     cmp;
    logic                     dz;
  } res_t;

  // side data travelling alongside the divider stages
  typedef struct packed {
    logic                     is_div;
    logic                     neg;
    logic                     dz;
    logic                     cmp;
    logic signed [DATA_W-1:0] res;
  } lane_t;

endpackage

// ===== design/fpalu_fifo.sv =====
// ----------------------------------------------------------------------------
// fpalu_fifo - small register queue
// Push/full and pop/empty queue used between the ALU stages. DEPTH must be
// a power of two.
// ----------------------------------------------------------------------------
module fpalu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fifo occupancy beyond depth");

endmodule

// ===== design/fpalu_front.sv =====
// ----------------------------------------------------------------------------
// fpalu_front - command intake and classification
// Takes items, sorts each command into its execution class and holds it in
// a short queue for the execute pipeline.
// ----------------------------------------------------------------------------
module fpalu_front
  import fpalu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [3:0]               command_i,
  input  logic signed [DATA_W-1:0] operand_a_i,
  input  logic signed [DATA_W-1:0] operand_b_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output logic                     empty_o,
  output front_item_t              item_o
);

  front_item_t item_in;
  logic [$bits(front_item_t)-1:0] q_out;
  cmd_e        cmd;
  op_class_e   cls;

  assign cmd = cmd_e'(command_i);

  always_comb begin
    unique case (cmd) inside
      CMD_MUL:                                        cls = CLS_MUL;
      CMD_DIV:                                        cls = CLS_DIV;
      CMD_LT, CMD_LE, CMD_GT, CMD_GE, CMD_EQ, CMD_NE: cls = CLS_CMP;
      default:                                        cls = CLS_SIMPLE;
    endcase
  end

  always_comb begin
    item_in.ctrl.cmd = cmd;
    item_in.ctrl.cls = cls;
    item_in.a        = operand_a_i;
    item_in.b        = operand_b_i;
  end

  fpalu_fifo #(
    .WIDTH ($bits(front_item_t)),
    .DEPTH (FRONT_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (item_in),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .data_o  (q_out)
  );

  assign item_o = front_item_t'(q_out);

endmodule

// ===== design/fpalu_divider.sv =====
// ----------------------------------------------------------------------------
// fpalu_divider - pipelined unsigned restoring divider
// BPS quotient bits per stage; the dividend register fills with quotient
// bits from the bottom as it shifts out at the top.
// ----------------------------------------------------------------------------
module fpalu_divider #(
  parameter int unsigned DVD_W = 40,
  parameter int unsigned DVS_W = 32,
  parameter int unsigned BPS   = 4
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned NSTG = (DVD_W + BPS - 1) / BPS;

  logic [DVD_W-1:0] dq_q   [NSTG];
  logic [DVS_W-1:0] rem_q  [NSTG];
  logic [DVS_W-1:0] dvs_q  [NSTG];
  logic [DVD_W-1:0] dq_d   [NSTG];
  logic [DVS_W-1:0] rem_d  [NSTG];
  logic [DVD_W-1:0] src_dq [NSTG];
  logic [DVS_W-1:0] src_rem[NSTG];
  logic [DVS_W-1:0] src_dvs[NSTG];

  always_comb begin
    src_dq[0]  = dividend_i;
    src_rem[0] = '0;
    src_dvs[0] = divisor_i;
    for (int s = 1; s < NSTG; s++) begin
      src_dq[s]  = dq_q[s-1];
      src_rem[s] = rem_q[s-1];
      src_dvs[s] = dvs_q[s-1];
    end
  end

  always_comb begin
    logic [DVD_W-1:0] dq;
    logic [DVS_W-1:0] rem;
    logic [DVS_W:0]   sh;
    logic [DVS_W:0]   diff;
    for (int s = 0; s < NSTG; s++) begin
      dq  = src_dq[s];
      rem = src_rem[s];
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < DVD_W) begin
          sh   = {rem, dq[DVD_W-1]};
          diff = sh - {1'b0, src_dvs[s]};
          if (sh >= {1'b0, src_dvs[s]}) begin
            rem = diff[DVS_W-1:0];
            dq  = {dq[DVD_W-2:0], 1'b1};
          end else begin
            rem = sh[DVS_W-1:0];
            dq  = {dq[DVD_W-2:0], 1'b0};
          end
        end
      end
      dq_d[s]  = dq;
      rem_d[s] = rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NSTG; s++) begin
        dq_q[s]  <= dq_d[s];
        rem_q[s] <= rem_d[s];
        dvs_q[s] <= src_dvs[s];
      end
    end
  end

  assign quotient_o = dq_q[NSTG-1];

endmodule

// ===== design/fpalu_back.sv =====
// ----------------------------------------------------------------------------
// fpalu_back - execute pipeline
// Operand register, one execute stage (adder, comparator, multiplier,
// divide set-up), then the divider stages with a matching side lane.
// ----------------------------------------------------------------------------
module fpalu_back
  import fpalu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mid_empty_i,
  input  front_item_t mid_item_i,
  output logic        mid_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output res_t        res_o
);

  localparam int unsigned DVD_W = DATA_W + FRAC_BITS;
  localparam int unsigned NSTG  = (DVD_W + DIV_BPS - 1) / DIV_BPS;

  logic adv;

  // operand stage
  logic                     s1_valid_q;
  op_ctrl_t                 s1_ctrl_q;
  logic signed [DATA_W-1:0] s1_a_q, s1_b_q;

  // execute stage
  logic                     s2_valid_q;
  op_class_e                s2_cls_q;
  logic signed [DATA_W-1:0] s2_res_q, simple_d;
  logic                     s2_cmp_q, cmp_d;
  logic                     s2_dz_q, dz_d;
  logic                     s2_neg_q, neg_d;
  logic signed [2*DATA_W-1:0] s2_prod_q, prod_d;
  logic [DATA_W-1:0]        s2_mag_a_q, s2_mag_b_q, mag_a_d, mag_b_d;

  // side lane alongside the divider
  logic  line_vld_q [NSTG];
  lane_t line_q     [NSTG];
  lane_t lane_in, lane_out;

  logic [DVD_W-1:0]  quotient;
  logic [DATA_W-1:0] q_lo;

  assign adv       = !res_full_i;
  assign mid_pop_o = adv && !mid_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      for (int s = 0; s < NSTG; s++) begin
        line_vld_q[s] <= 1'b0;
      end
    end else if (adv) begin
      s1_valid_q    <= !mid_empty_i;
      s2_valid_q    <= s1_valid_q;
      line_vld_q[0] <= s2_valid_q;
      for (int s = 1; s < NSTG; s++) begin
        line_vld_q[s] <= line_vld_q[s-1];
      end
    end
  end

  always_comb begin
    unique case (s1_ctrl_q.cmd)
      CMD_ADD:      simple_d = s1_a_q + s1_b_q;
      CMD_SUB:      simple_d = s1_a_q - s1_b_q;
      CMD_INC:      simple_d = s1_a_q + DATA_W'(1);
      CMD_DEC:      simple_d = s1_a_q - DATA_W'(1);
      CMD_FROM_INT: simple_d = s1_a_q << FRAC_BITS;
      CMD_TO_INT:   simple_d = s1_a_q >>> FRAC_BITS;
      CMD_MIN:      simple_d = (s1_a_q < s1_b_q) ? s1_a_q : s1_b_q;
      CMD_MAX:      simple_d = (s1_a_q > s1_b_q) ? s1_a_q : s1_b_q;
      default:      simple_d = '0;
    endcase
  end

  always_comb begin
    unique case (s1_ctrl_q.cmd)
      CMD_LT:  cmp_d = s1_a_q <  s1_b_q;
      CMD_LE:  cmp_d = s1_a_q <= s1_b_q;
      CMD_GT:  cmp_d = s1_a_q >  s1_b_q;
      CMD_GE:  cmp_d = s1_a_q >= s1_b_q;
      CMD_EQ:  cmp_d = s1_a_q == s1_b_q;
      CMD_NE:  cmp_d = s1_a_q != s1_b_q;
      default: cmp_d = 1'b0;
    endcase
  end

  assign prod_d  = s1_a_q * s1_b_q;
  assign mag_a_d = s1_a_q[DATA_W-1] ? DATA_W'(0) - $unsigned(s1_a_q) : $unsigned(s1_a_q);
  assign mag_b_d = s1_b_q[DATA_W-1] ? DATA_W'(0) - $unsigned(s1_b_q) : $unsigned(s1_b_q);
  assign neg_d   = s1_a_q[DATA_W-1] ^ s1_b_q[DATA_W-1];
  assign dz_d    = (s1_ctrl_q.cls == CLS_DIV) && (s1_b_q == '0);

  always_comb begin
    lane_in.is_div = (s2_cls_q == CLS_DIV);
    lane_in.neg    = s2_neg_q;
    lane_in.dz     = s2_dz_q;
    lane_in.cmp    = s2_cmp_q;
    lane_in.res    = (s2_cls_q == CLS_MUL) ? s2_prod_q[FRAC_BITS+DATA_W-1:FRAC_BITS]
                                           : s2_res_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctrl_q  <= mid_item_i.ctrl;
      s1_a_q     <= mid_item_i.a;
      s1_b_q     <= mid_item_i.b;
      s2_cls_q   <= s1_ctrl_q.cls;
      s2_res_q   <= simple_d;
      s2_cmp_q   <= cmp_d;
      s2_dz_q    <= dz_d;
      s2_neg_q   <= neg_d;
      s2_prod_q  <= prod_d;
      s2_mag_a_q <= mag_a_d;
      s2_mag_b_q <= mag_b_d;
      line_q[0]  <= lane_in;
      for (int s = 1; s < NSTG; s++) begin
        line_q[s] <= line_q[s-1];
      end
    end
  end

  fpalu_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DATA_W),
    .BPS   (DIV_BPS)
  ) u_div (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i ({s2_mag_a_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (s2_mag_b_q),
    .quotient_o (quotient)
  );

  assign lane_out = line_q[NSTG-1];
  assign q_lo     = quotient[DATA_W-1:0];

  always_comb begin
    res_o.cmp = lane_out.cmp;
    res_o.dz  = lane_out.dz;
    if (!lane_out.is_div) begin
      res_o.value = lane_out.res;
    end else if (lane_out.dz) begin
      res_o.value = '0;
    end else if (lane_out.neg) begin
      res_o.value = $signed(DATA_W'(0) - q_lo);
    end else begin
      res_o.value = $signed(q_lo);
    end
  end

  assign res_push_o = adv && line_vld_q[NSTG-1];

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.dz) |-> (res_o.value == '0 && !res_o.cmp))
    else $error("divide by zero with non-zero result");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_a_q) && $stable(s1_b_q)))
    else $error("operand stage lost its item during a stall");

endmodule

// ===== design/fixed_point_q24_8_alu_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit - signed Q24.8 fixed-point ALU
// Add, subtract, multiply, divide, step, conversions, compares, min/max.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Input channel: an item (command, operand_a, operand_b) transfers on a
//    rising edge with push high and full low. Operands are raw two's
//    complement values with FRAC_BITS fraction bits.
//  - Result channel: while empty is low the oldest result sits on
//    result_value_o/compare_true_o/divide_by_zero_o; it transfers on a rising
//    edge with pop high.
//  - One result per item, in order. Division by zero returns 0 with
//    divide_by_zero_o set. Value results wrap to 32 bits.
//  - Throughput: one item per cycle while the result queue is not full.
//    The divider is a pipeline of ceil((32 + FRAC_BITS) / 4) stages, four
//    quotient bits each, and every command travels the same path so
//    results stay in order. Each item passes the front queue, the operand
//    register, the execute stage, the divider stages and the result queue.
//  - Stall: when the result queue fills, the whole execute pipeline holds;
//    the front queue keeps taking items until it is full too.
//  - Reset empties both queues and the pipeline; no item is lost or
//    invented across a stall.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_unit
  import fpalu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [3:0]               command_i,
  input  logic signed [DATA_W-1:0] operand_a_i,
  input  logic signed [DATA_W-1:0] operand_b_i,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic                     compare_true_o,
  output logic                     divide_by_zero_o
);

  // front queue to execute pipeline
  logic        mid_empty;
  logic        mid_pop;
  front_item_t mid_item;

  // execute pipeline to result queue
  logic        res_full;
  logic        res_push;
  res_t        res_in;
  logic [$bits(res_t)-1:0] res_raw;
  res_t        res_out;

  // intake: classify and buffer
  fpalu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .full_o      (full),
    .pop_i       (mid_pop),
    .empty_o     (mid_empty),
    .item_o      (mid_item)
  );

  // execute: arithmetic, compare, multiply, pipelined divide
  fpalu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_item),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue decouples the pipeline from the consumer
  fpalu_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_raw)
  );

  assign res_out          = res_t'(res_raw);
  assign result_value_o   = res_out.value;
  assign compare_true_o   = res_out.cmp;
  assign divide_by_zero_o = res_out.dz;

endmodule
